### hw/rtl/cbor_pkg.sv
// Shared types, constants and the argument-header helper for the CBOR item encoder.
// Depends on nothing; every other file imports it.
`default_nettype none

package cbor_pkg;

	localparam int unsigned KindW   = 4;
	localparam int unsigned ArgW    = 64;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned FollowW = 4;
	localparam int unsigned QDepth  = 2;
	localparam int unsigned QPtrW   = $clog2(QDepth);
	localparam int unsigned QCntW   = $clog2(QDepth + 1);

	localparam logic [FollowW-1:0] MaxFollow = FollowW'(8);

	typedef enum logic [KindW-1:0] {
		REQ_UINT      = 4'd0,
		REQ_SINT      = 4'd1,
		REQ_BSTR      = 4'd2,
		REQ_TSTR      = 4'd3,
		REQ_ARRAY     = 4'd4,
		REQ_MAP       = 4'd5,
		REQ_TAG       = 4'd6,
		REQ_ARR_INDEF = 4'd7,
		REQ_MAP_INDEF = 4'd8,
		REQ_BREAK     = 4'd9,
		REQ_NULL      = 4'd10,
		REQ_UNDEF     = 4'd11,
		REQ_BOOL      = 4'd12,
		REQ_F32       = 4'd13,
		REQ_F64       = 4'd14,
		REQ_RAW       = 4'd15
	} cbor_kind_t;

	typedef enum logic [2:0] {
		MT_UINT   = 3'd0,
		MT_NINT   = 3'd1,
		MT_BSTR   = 3'd2,
		MT_TSTR   = 3'd3,
		MT_ARRAY  = 3'd4,
		MT_MAP    = 3'd5,
		MT_TAG    = 3'd6,
		MT_SIMPLE = 3'd7
	} cbor_major_t;

	localparam logic [4:0] AI_1B = 5'd24;
	localparam logic [4:0] AI_2B = 5'd25;
	localparam logic [4:0] AI_4B = 5'd26;
	localparam logic [4:0] AI_8B = 5'd27;

	localparam logic [ByteW-1:0] B_ARR_INDEF = 8'h9f;
	localparam logic [ByteW-1:0] B_MAP_INDEF = 8'hbf;
	localparam logic [ByteW-1:0] B_BREAK     = 8'hff;
	localparam logic [ByteW-1:0] B_NULL      = 8'hf6;
	localparam logic [ByteW-1:0] B_UNDEF     = 8'hf7;
	localparam logic [ByteW-1:0] B_TRUE      = 8'hf5;
	localparam logic [ByteW-1:0] B_FALSE     = 8'hf4;
	localparam logic [ByteW-1:0] B_F32       = 8'hfa;
	localparam logic [ByteW-1:0] B_F64       = 8'hfb;

	typedef struct packed {
		logic [ByteW-1:0]   head;
		logic [FollowW-1:0] nfollow;
		logic [ArgW-1:0]    arg;
	} cbor_entry_t;

	function automatic cbor_entry_t head_entry(cbor_major_t mt, logic [ArgW-1:0] a);
		cbor_entry_t e;
		e.arg = a;
		if (a < ArgW'(24)) begin
			e.head    = {mt, a[4:0]};
			e.nfollow = FollowW'(0);
		end else if (a[ArgW-1:8] == '0) begin
			e.head    = {mt, AI_1B};
			e.nfollow = FollowW'(1);
		end else if (a[ArgW-1:16] == '0) begin
			e.head    = {mt, AI_2B};
			e.nfollow = FollowW'(2);
		end else if (a[ArgW-1:32] == '0) begin
			e.head    = {mt, AI_4B};
			e.nfollow = FollowW'(4);
		end else begin
			e.head    = {mt, AI_8B};
			e.nfollow = MaxFollow;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/cbor_if.sv
// Valid/ready channel interfaces: encode requests in, encoded bytes out.
// Depends on cbor_pkg for field widths.
`default_nettype none

interface cbor_req_if import cbor_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KindW-1:0] req_type;
	logic [ArgW-1:0]  item_value;

	modport source (output valid, req_type, item_value, input ready);
	modport sink (input valid, req_type, item_value, output ready);
endinterface

interface cbor_byte_if import cbor_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] out_byte;
	logic             last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/cbor_classify.sv
// Front end: accepts requests and turns each into an initial byte, a
// following-byte count and an argument. Depends on cbor_pkg and cbor_req_if.
`default_nettype none

module cbor_classify import cbor_pkg::*; (
	cbor_req_if.sink    req,
	output logic        push_valid,
	input  logic        push_ready,
	output cbor_entry_t push_entry
);

	cbor_kind_t      kind;
	logic [ArgW-1:0] v;

	assign kind       = cbor_kind_t'(req.req_type);
	assign v          = req.item_value;
	assign push_valid = req.valid;
	assign req.ready  = push_ready;

	always_comb begin
		push_entry = '{head: '0, nfollow: '0, arg: v};
		unique case (kind)
			REQ_UINT: push_entry = head_entry(MT_UINT, v);
			REQ_SINT: begin
				if (v[ArgW-1]) push_entry = head_entry(MT_NINT, ~v);
				else push_entry = head_entry(MT_UINT, v);
			end
			REQ_BSTR, REQ_TSTR, REQ_ARRAY, REQ_MAP, REQ_TAG:
				push_entry = head_entry(cbor_major_t'(kind[2:0]), v);
			REQ_ARR_INDEF: push_entry.head = B_ARR_INDEF;
			REQ_MAP_INDEF: push_entry.head = B_MAP_INDEF;
			REQ_BREAK:     push_entry.head = B_BREAK;
			REQ_NULL:      push_entry.head = B_NULL;
			REQ_UNDEF:     push_entry.head = B_UNDEF;
			REQ_BOOL:      push_entry.head = v[0] ? B_TRUE : B_FALSE;
			REQ_F32: begin
				push_entry.head    = B_F32;
				push_entry.nfollow = FollowW'(4);
				push_entry.arg     = {32'd0, v[31:0]};
			end
			REQ_F64: begin
				push_entry.head    = B_F64;
				push_entry.nfollow = MaxFollow;
			end
			REQ_RAW: push_entry.head = v[ByteW-1:0];
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/cbor_queue.sv
// Short FIFO of classified items between the front end and the serialiser.
// Depends on cbor_pkg.
`default_nettype none

module cbor_queue import cbor_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  cbor_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop,
	output cbor_entry_t head
);

	cbor_entry_t      entries_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != QCntW'(QDepth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cbor_emit.sv
// Back end: walks the queue head one byte per beat into a registered output.
// Depends on cbor_pkg and cbor_byte_if.
`default_nettype none

module cbor_emit import cbor_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cbor_entry_t q_head,
	output logic        pop,
	cbor_byte_if.source enc
);

	logic [FollowW-1:0] cnt_q;
	logic               out_valid_q;
	logic [ByteW-1:0]   out_byte_q;
	logic               last_q;
	logic               adv;
	logic               last_now;
	logic [FollowW-1:0] sel;
	logic [ByteW-1:0]   cur_byte;

	assign adv      = !out_valid_q || enc.ready;
	assign last_now = (cnt_q == q_head.nfollow);
	assign sel      = q_head.nfollow - cnt_q;
	assign cur_byte = (cnt_q == '0) ? q_head.head : q_head.arg[{sel[2:0], 3'b000} +: ByteW];
	assign pop      = adv && q_valid && last_now;

	assign enc.valid     = out_valid_q;
	assign enc.out_byte  = out_byte_q;
	assign enc.last_byte = last_q;

	always_ff @(posedge clk) begin
		if (adv && q_valid) begin
			out_byte_q <= cur_byte;
			last_q     <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (adv) begin
			out_valid_q <= q_valid;
			if (q_valid) cnt_q <= last_now ? '0 : cnt_q + 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MaxFollow)
		else $error("byte counter beyond longest argument");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (q_valid && cnt_q <= q_head.nfollow))
		else $error("queue head lost or overrun mid-item");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (enc.valid && enc.last_byte && cnt_q == '0))
		else $error("item retired without flagging its last byte");

endmodule

`default_nettype wire

### hw/rtl/cbor_item_encoder.sv
// CBOR data item encoder top level: front end, item queue and byte serialiser.
// Depends on cbor_pkg, cbor_if, cbor_classify, cbor_queue and cbor_emit.
//
// Each request (kind plus 64-bit operand) yields its CBOR encoding on the byte
// channel, most significant byte first, with last_byte set on the final byte.
// An item is serialised as 1 + n bytes, where n is 0, 1, 2, 4 or 8 following
// argument bytes (8 for the longest: 8-byte argument or float64), so one-byte
// items stream at one per cycle while enc.ready does not stall the output. The
// serialiser's single byte-wide output register sets that rate; a two-entry
// queue in front of it lets requests be taken while earlier bytes still drain.
// A request's first byte is held in a queue entry, then in the output register.
`default_nettype none

module cbor_item_encoder import cbor_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cbor_req_if.sink    req,
	cbor_byte_if.source enc
);

	logic        push_valid;
	logic        push_ready;
	cbor_entry_t push_entry;
	logic        q_valid;
	logic        pop;
	cbor_entry_t q_head;

	cbor_classify u_classify (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	cbor_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (q_valid),
		.pop        (pop),
		.head       (q_head)
	);

	cbor_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.enc     (enc)
	);

endmodule

`default_nettype wire
